/* hdl/sma_pkg.sv */
// ----------------------------------------------------------------------------
// sma_pkg
// Shared word type, command codes and status codes for the stack machine ALU.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int WORD_W  = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 3;
	localparam int DEPTH_W = 9;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] stat_t;

	// command codes
	localparam cmd_t CMD_PUSH = 3'd0;
	localparam cmd_t CMD_ADD  = 3'd1;
	localparam cmd_t CMD_SUB  = 3'd2;
	localparam cmd_t CMD_MUL  = 3'd3;
	localparam cmd_t CMD_DIV  = 3'd4;
	localparam cmd_t CMD_MOD  = 3'd5;

	// status codes
	localparam stat_t ST_OK        = 3'd0;
	localparam stat_t ST_UNDERFLOW = 3'd1;
	localparam stat_t ST_DIVZERO   = 3'd2;
	localparam stat_t ST_OVERFLOW  = 3'd3;
	localparam stat_t ST_HALTED    = 3'd4;

endpackage

/* hdl/sma_stack_mem.sv */
// ----------------------------------------------------------------------------
// sma_stack_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sma_stack_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  sma_pkg::word_t wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output sma_pkg::word_t rd_data
);

	sma_pkg::word_t mem [DEPTH];
	sma_pkg::word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/sma_divider.sv */
// ----------------------------------------------------------------------------
// sma_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sma_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sma_pkg::word_t dividend,
	input  sma_pkg::word_t divisor,
	output logic           done,
	output sma_pkg::word_t quotient,
	output sma_pkg::word_t remainder
);

	localparam int W  = sma_pkg::WORD_W;
	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// pulses the cycle after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// trial subtract; keep it when it does not borrow
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/stack_machine_alu.sv */
// ----------------------------------------------------------------------------
// stack_machine_alu
// Data stack of 32-bit words with add, sub, mul, div and mod on the top two.
// ----------------------------------------------------------------------------
//
//  channel   signals                           beat
//  -------   -------------------------------   ------------------------------
//  cmd       cmd_valid / cmd_stall             command, push_value
//  res       res_valid / res_stall             top_value, status, running, depth
//
// Push and rejected/halted commands: IDLE, WB; add/sub/mul: IDLE, READ, WB;
// div/mod: IDLE, READ, DIV, WB, with DIV in the one-bit-per-cycle divider.
// The stack lives in a one-port-read, one-port-write synchronous RAM; the top
// entry is also cached in a register, so only the second operand is read.
// Reset clears stack pointer and sets running; RAM contents are not cleared.
// A result waits in the output register; a new command is taken meanwhile,
// and its write-back waits until the output register is free.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [2:0]               command,
	input  logic signed [31:0]       push_value,

	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [31:0]       top_value,
	output logic [2:0]               status,
	output logic                     running,
	output logic [8:0]               depth
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int W   = sma_pkg::WORD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_WB
	} state_t;

	function automatic sma_pkg::word_t mag(input sma_pkg::word_t v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	state_t          state_q;

	// architectural state outside the RAM
	logic [SPW-1:0]  sp_q;
	sma_pkg::word_t  tos_q;        // copy of the RAM entry at sp-1
	logic            running_q;

	// command in flight
	sma_pkg::cmd_t   op_q;
	sma_pkg::word_t  data_q;       // push value, later the ALU result
	sma_pkg::stat_t  pend_status_q;
	logic            push_q;
	logic            arith_q;
	logic            fail_q;
	logic            qneg_q;
	logic            rneg_q;

	// output register
	logic            res_valid_q;
	sma_pkg::word_t  res_top_q;
	sma_pkg::stat_t  res_status_q;
	logic            res_running_q;
	logic [sma_pkg::DEPTH_W-1:0] res_depth_q;

	logic            accept;
	logic            res_free;
	logic            wb_fire;
	logic [SPW-1:0]  rd_idx;
	logic [SPW-1:0]  wb_sp;
	sma_pkg::word_t  wb_tos;
	logic            is_arith;
	logic            is_divide;

	// decode of the incoming command
	sma_pkg::stat_t  dec_status;
	logic            dec_push;
	logic            dec_arith;
	logic            dec_fail;

	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	sma_pkg::word_t  mem_rd_data;

	logic            div_start;
	logic            div_done;
	sma_pkg::word_t  div_quo;
	sma_pkg::word_t  div_rem;
	sma_pkg::word_t  opnd_a;
	sma_pkg::word_t  opnd_b;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign res_free  = !res_valid_q || !res_stall;
	assign wb_fire   = (state_q == S_WB) && res_free;

	assign is_arith  = (command == sma_pkg::CMD_ADD) || (command == sma_pkg::CMD_SUB) ||
	                   (command == sma_pkg::CMD_MUL) || (command == sma_pkg::CMD_DIV) ||
	                   (command == sma_pkg::CMD_MOD);
	assign is_divide = (command == sma_pkg::CMD_DIV) || (command == sma_pkg::CMD_MOD);

	// checks use pointer and cached top only
	always_comb begin
		dec_status = sma_pkg::ST_OK;
		dec_push   = 1'b0;
		dec_arith  = 1'b0;
		dec_fail   = 1'b0;
		priority if (!running_q) begin
			dec_status = sma_pkg::ST_HALTED;
		end else if (command == sma_pkg::CMD_PUSH) begin
			if (sp_q == SPW'(STACK_DEPTH)) begin
				dec_status = sma_pkg::ST_OVERFLOW;
				dec_fail   = 1'b1;
			end else begin
				dec_push = 1'b1;
			end
		end else if (is_arith) begin
			priority if (sp_q < SPW'(2)) begin
				dec_status = sma_pkg::ST_UNDERFLOW;
				dec_fail   = 1'b1;
			end else if (is_divide && (tos_q == '0)) begin
				dec_status = sma_pkg::ST_DIVZERO;
				dec_fail   = 1'b1;
			end else begin
				dec_arith = 1'b1;
			end
		end else begin
			// unused codes: no effect, status ok
			dec_status = sma_pkg::ST_OK;
		end
	end

	// second operand sits one below the top
	assign rd_idx = sp_q - SPW'(2);

	assign wb_sp  = push_q  ? (sp_q + SPW'(1)) :
	                arith_q ? (sp_q - SPW'(1)) : sp_q;
	assign wb_tos = (push_q || arith_q) ? data_q : tos_q;

	// RAM write-back: push writes at sp, a binary op overwrites a at sp-2.
	// The FSM only reads in S_IDLE, always after the previous write edge,
	// so no read/write overlap on one entry can occur.
	assign mem_wr_en   = wb_fire && (push_q || arith_q);
	assign mem_wr_addr = push_q ? sp_q[AW-1:0] : rd_idx[AW-1:0];

	sma_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (data_q),
		.rd_en   (accept),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_data (mem_rd_data)
	);

	assign opnd_a    = mem_rd_data;
	assign opnd_b    = tos_q;
	assign div_start = (state_q == S_READ) &&
	                   ((op_q == sma_pkg::CMD_DIV) || (op_q == sma_pkg::CMD_MOD));

	sma_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag(opnd_a)),
		.divisor   (mag(opnd_b)),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sp_q          <= '0;
			running_q     <= 1'b1;
			push_q        <= 1'b0;
			arith_q       <= 1'b0;
			fail_q        <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			// a new result loads the output register, a taken one empties it
			if (wb_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q          <= command;
						data_q        <= push_value;
						push_q        <= dec_push;
						arith_q       <= dec_arith;
						fail_q        <= dec_fail;
						pend_status_q <= dec_status;
						state_q       <= dec_arith ? S_READ : S_WB;
					end
				end
				S_READ: begin
					// a is now on the RAM read port, b is the cached top
					unique case (op_q)
						sma_pkg::CMD_ADD: begin
							data_q  <= opnd_a + opnd_b;
							state_q <= S_WB;
						end
						sma_pkg::CMD_SUB: begin
							data_q  <= opnd_a - opnd_b;
							state_q <= S_WB;
						end
						sma_pkg::CMD_MUL: begin
							data_q  <= opnd_a * opnd_b;
							state_q <= S_WB;
						end
						sma_pkg::CMD_DIV,
						sma_pkg::CMD_MOD: begin
							qneg_q  <= opnd_a[W-1] ^ opnd_b[W-1];
							rneg_q  <= opnd_a[W-1];
							state_q <= S_DIV;
						end
						default: state_q <= S_WB;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						// quotient truncates toward zero, remainder follows a
						if (op_q == sma_pkg::CMD_DIV) begin
							data_q <= qneg_q ? (~div_quo + W'(1)) : div_quo;
						end else begin
							data_q <= rneg_q ? (~div_rem + W'(1)) : div_rem;
						end
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (res_free) begin
						sp_q          <= wb_sp;
						tos_q         <= wb_tos;
						running_q     <= running_q && !fail_q;
						res_top_q     <= (wb_sp == '0) ? '0 : wb_tos;
						res_status_q  <= pend_status_q;
						res_running_q <= running_q && !fail_q;
						res_depth_q   <= sma_pkg::DEPTH_W'(wb_sp);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign top_value = res_top_q;
	assign status    = res_status_q;
	assign running   = res_running_q;
	assign depth     = res_depth_q;

	// pointer never passes the stack size
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack size");

	// once halted, stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |=> !running_q)
		else $error("running flag set again without reset");

	// a halted result never reports running
	a_halted_res: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_status_q == sma_pkg::ST_HALTED)) |-> !res_running_q)
		else $error("halted result reports running");

	// divider finishes only while the FSM waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("command taken while another is in flight");

endmodule
